// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro clocks on the rising edge of the given clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pli_pkg.sv -----
// Shared types and sizes for the piecewise linear interpolator.
// No dependencies; pli_div, the top level and pli_checker import it.
`default_nettype none

package pli_pkg;

	// Table and field sizes
	localparam int MAX_POINTS = 64;
	localparam int TIME_BITS  = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = 7;

	// Divider sizes: offset times value step, quotient no wider than the step
	localparam int PROD_BITS  = TIME_BITS + VALUE_BITS + 1;
	localparam int STEP_BITS  = $clog2(PROD_BITS + 1);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EVAL = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REGION_BEFORE  = 2'd0,
		REGION_INTERP  = 2'd1,
		REGION_AFTER   = 2'd2,
		REGION_NOMATCH = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_CHECK,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} pli_div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pli_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the point time and point value tables.
`default_nettype none

module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, and register one read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pli_div.sv -----
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on pli_pkg for the operand widths and the status struct.
`default_nettype none

module pli_div import pli_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [PROD_BITS-1:0]  dividend,
	input  wire logic [TIME_BITS-1:0]  divisor,
	output pli_div_stat_t              stat,
	output logic      [VALUE_BITS-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [PROD_BITS-1:0] num_q;
	logic [TIME_BITS-1:0] den_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;

	logic [TIME_BITS:0]   rem_sh;
	logic [TIME_BITS:0]   rem_sub;
	logic                 fits;
	logic                 last_step;

	// Shift in the next dividend bit and try one subtraction
	always_comb begin
		rem_sh    = {rem_q, num_q[PROD_BITS-1]};
		rem_sub   = rem_sh - {1'b0, den_q};
		fits      = rem_sh >= {1'b0, den_q};
		last_step = (cnt_q == STEP_BITS'(1));
	end

	// Control: count down the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_BITS'(PROD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder stays below the divisor, upper quotient bits are zero
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_BITS-2:0], 1'b0};
			rem_q <= fits ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator: point times and values sit in two RAMs with a registered
// read (pli_ram), filled by load words; an evaluate word clamps below the first or at/after
// the last point, else scans segments one RAM read per cycle and interpolates with a 32x33
// multiply and the bit-serial divider in pli_div (uses pli_pkg), or reports no match if no
// segment holds it. A load writes both tables in its accepting cycle. A clamped evaluate
// goes through RD_FIRST, RD_LAST, CHECK and DONE; an interpolated one scans s segments
// (1 to point_count-1) in SCAN, then MUL, the divider's 65 quotient steps in DIV, and DONE.
// New words are not accepted during an evaluate; a finished result waits in the output
// register while the next word is taken. point_count is written through cfg and read as 1
// when zero and as the table depth when larger; write it only while the block is idle.
`default_nettype none

module piecewise_linear_interpolator import pli_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration write
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic        [CNT_BITS-1:0]   cfg_data,
	// Input words
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         action,
	input  wire logic        [IDX_BITS-1:0]   point_index,
	input  wire logic        [TIME_BITS-1:0]  sample_time,
	input  wire logic signed [VALUE_BITS-1:0] point_value,
	// Result words
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed      [VALUE_BITS-1:0] curve_value,
	output logic             [1:0]            region,
	output logic             [IDX_BITS-1:0]   segment
);

	state_t state_q, state_d;

	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   count_eff;
	logic [CNT_BITS-1:0]   last_full;
	logic [IDX_BITS-1:0]   last_idx;

	logic                  in_acc;
	logic                  load_we;
	logic [IDX_BITS-1:0]   rd_addr;
	logic [TIME_BITS-1:0]  t_rd;
	logic [VALUE_BITS-1:0] v_rd;

	logic [TIME_BITS-1:0]  query_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [TIME_BITS-1:0]  prev_t_q;
	logic [VALUE_BITS-1:0] prev_v_q;
	logic                  hit;

	logic [TIME_BITS-1:0]  ofs_q;
	logic [TIME_BITS-1:0]  dt_q;
	logic [VALUE_BITS-1:0] base_v_q;
	logic [VALUE_BITS:0]   mag_q;
	logic                  neg_q;
	logic [VALUE_BITS:0]   dv;
	logic [PROD_BITS-1:0]  prod;

	logic                  div_start;
	pli_div_stat_t         div_stat;
	logic [VALUE_BITS-1:0] quo;

	logic [VALUE_BITS-1:0] res_val_q;
	region_t               res_region_q;
	logic [IDX_BITS-1:0]   res_seg_q;

	logic                  out_load;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] curve_q;
	region_t               region_q;
	logic [IDX_BITS-1:0]   seg_q;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// Clamp the point count to one up to the table depth
	always_comb begin
		if (count_q == '0) begin
			count_eff = CNT_BITS'(1);
		end else if (count_q > CNT_BITS'(MAX_POINTS)) begin
			count_eff = CNT_BITS'(MAX_POINTS);
		end else begin
			count_eff = count_q;
		end
		last_full = count_eff - 1'b1;
		last_idx  = last_full[IDX_BITS-1:0];
	end

	// Loads write both tables in the accepting cycle; no read is pending then
	assign in_acc  = in_valid && !in_stall;
	assign load_we = in_acc && (action == ACT_LOAD)
		&& (CNT_BITS'(point_index) < CNT_BITS'(MAX_POINTS));

	pli_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_POINTS)) u_time_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (point_index),
		.wdata (sample_time),
		.raddr (rd_addr),
		.rdata (t_rd)
	);

	pli_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_POINTS)) u_value_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (point_index),
		.wdata (point_value),
		.raddr (rd_addr),
		.rdata (v_rd)
	);

	// Segment test: previous point at or below the query, current point above it
	assign hit = (prev_t_q <= query_q) && (t_rd > query_q);

	// Value step of the hit segment in two's complement, one bit wider than a value
	assign dv = {v_rd[VALUE_BITS-1], v_rd} - {prev_v_q[VALUE_BITS-1], prev_v_q};

	// Offset times step magnitude, registered inside the divider
	assign prod = ofs_q * mag_q;

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (dt_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, read address, divider start and output load
	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && action == ACT_EVAL) begin
					state_d = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				rd_addr = '0;
				state_d = ST_RD_LAST;
			end
			ST_RD_LAST: begin
				rd_addr = last_idx;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				rd_addr = IDX_BITS'(1);
				if (query_q < prev_t_q || query_q >= t_rd) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = idx_q + 1'b1;
				if (hit) begin
					state_d = ST_MUL;
				end else if (idx_q == last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Evaluate datapath: capture points, pick the region, build the result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					query_q <= sample_time;
				end
			end
			ST_RD_LAST: begin
				prev_t_q <= t_rd;
				prev_v_q <= v_rd;
			end
			ST_CHECK: begin
				idx_q     <= IDX_BITS'(1);
				res_seg_q <= '0;
				if (query_q < prev_t_q) begin
					res_val_q    <= prev_v_q;
					res_region_q <= REGION_BEFORE;
				end else if (query_q >= t_rd) begin
					res_val_q    <= v_rd;
					res_region_q <= REGION_AFTER;
				end else begin
					res_val_q    <= v_rd;
					res_region_q <= REGION_NOMATCH;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ofs_q        <= query_q - prev_t_q;
					dt_q         <= t_rd - prev_t_q;
					base_v_q     <= prev_v_q;
					neg_q        <= dv[VALUE_BITS];
					mag_q        <= dv[VALUE_BITS] ? (~dv + 1'b1) : dv;
					res_region_q <= REGION_INTERP;
					res_seg_q    <= idx_q - 1'b1;
				end else begin
					prev_t_q <= t_rd;
					prev_v_q <= v_rd;
					idx_q    <= idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_val_q <= neg_q ? (base_v_q - quo) : (base_v_q + quo);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			curve_q  <= res_val_q;
			region_q <= res_region_q;
			seg_q    <= res_seg_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign curve_value = curve_q;
	assign region      = region_q;
	assign segment     = seg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pli_checker.sv -----
// Port-level checks for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg for codes and on assert_macros.svh for the assertion forms.
`default_nettype none

`include "assert_macros.svh"

module pli_checker import pli_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  action,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [VALUE_BITS-1:0] curve_value,
	input wire logic [1:0]            region,
	input wire logic [IDX_BITS-1:0]   segment
);

	logic                           eval_acc;
	logic                           load_acc;
	logic                           clamped;
	logic                           out_held;
	logic [VALUE_BITS+IDX_BITS+1:0] out_word;

	// Handshake terms and the whole result word
	assign eval_acc = in_valid && !in_stall && action == ACT_EVAL;
	assign load_acc = in_valid && !in_stall && action == ACT_LOAD;
	assign clamped  = out_valid && region != REGION_INTERP;
	assign out_held = out_valid && out_stall;
	assign out_word = {curve_value, region, segment};

	// An evaluate word occupies the block: the next word must wait
	`ASSERT_NEXT(a_eval_busy, clk, arst_n, eval_acc, in_stall, "evaluate did not stall input")

	// A load word finishes in its own cycle
	`ASSERT_NEXT(a_load_free, clk, arst_n, load_acc, !in_stall, "load left input stalled")

	// Segment is zero unless the result was interpolated
	`ASSERT_IMPL(a_seg_zero, clk, arst_n, clamped, segment == '0, "segment set on clamped result")

	// A stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(out_word), "held word moved")

endmodule

bind piecewise_linear_interpolator pli_checker u_checker (.*);

`default_nettype wire
